// ===== rtl/hnt_pkg.sv =====
`default_nettype none
package hnt_pkg;
  localparam int DEF_VALUE_BITS = 40;
  localparam int DSUM_OUT_BITS  = 7;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;
endpackage
`default_nettype wire

// ===== rtl/hnt_front.sv =====
`default_nettype none
module hnt_front import hnt_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int NDIG       = (VALUE_BITS * 30103) / 100000 + 1,
  parameter int SUM_BITS   = $clog2(9 * NDIG + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [VALUE_BITS-1:0] value,
  input  q_stat_t                    qstat,
  output logic                       qwr,
  output logic [VALUE_BITS-1:0]      qval,
  output logic [SUM_BITS-1:0]        qsum
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;
  localparam int CW = $clog2(VALUE_BITS + NDIG + 1);

  logic [1:0]            state;
  logic [VALUE_BITS-1:0] val;
  logic [VALUE_BITS-1:0] shreg;
  logic [4*NDIG-1:0]     bcd;
  logic [4*NDIG-1:0]     bcd_adj;
  logic [SUM_BITS-1:0]   acc;
  logic [CW-1:0]         cnt;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  assign full = (state != S_IDLE);
  assign qwr  = (state == S_PUSH) && !qstat.full;
  assign qval = val;
  assign qsum = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (push) begin
          val   <= value;
          shreg <= value;
          bcd   <= '0;
          cnt   <= '0;
          state <= S_CONV;
        end
        S_CONV: begin
          bcd   <= {bcd_adj[4*NDIG-2:0], shreg[VALUE_BITS-1]};
          shreg <= shreg << 1;
          if (cnt == CW'(VALUE_BITS - 1)) begin
            cnt   <= '0;
            acc   <= '0;
            state <= S_SUM;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SUM: begin
          // add one digit a beat, low digit first
          acc <= acc + SUM_BITS'(bcd[3:0]);
          bcd <= bcd >> 4;
          if (cnt == CW'(NDIG - 1)) state <= S_PUSH;
          else cnt <= cnt + 1'b1;
        end
        S_PUSH: if (!qstat.full) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/hnt_fifo.sv =====
`default_nettype none
module hnt_fifo import hnt_pkg::*; #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr,
  input  wire logic [W-1:0] wdata,
  input  wire logic         rd,
  output logic [W-1:0]      rdata,
  output q_stat_t           stat
);
  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign rdata      = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !stat.full) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !stat.full) wptr <= !wptr;
      if (rd && !stat.empty) rptr <= !rptr;
      count <= count + 2'(wr && !stat.full) - 2'(rd && !stat.empty);
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
endmodule
`default_nettype wire

// ===== rtl/hnt_back.sv =====
`default_nettype none
module hnt_back import hnt_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int SUM_BITS   = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  q_stat_t                    qstat,
  input  wire logic [VALUE_BITS-1:0] qval,
  input  wire logic [SUM_BITS-1:0]   qsum,
  output logic                       qrd,
  output logic                       empty,
  input  wire logic                  pop,
  output logic                       niven,
  output logic [DSUM_OUT_BITS-1:0]   digit_sum,
  output logic                       zero_input
);
  localparam int CW = $clog2(VALUE_BITS + 1);

  logic                  busy;
  logic                  ovalid;
  logic [VALUE_BITS-1:0] shreg;
  logic [SUM_BITS-1:0]   s;
  logic [SUM_BITS-1:0]   r;
  logic [SUM_BITS:0]     r2;
  logic [CW-1:0]         cnt;

  assign r2    = {r, shreg[VALUE_BITS-1]};
  assign qrd   = !busy && !ovalid && !qstat.empty;
  assign empty = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (pop && ovalid) ovalid <= 1'b0;
      if (qrd) begin
        digit_sum <= DSUM_OUT_BITS'(qsum);
        s         <= qsum;
        shreg     <= qval;
        r         <= '0;
        cnt       <= '0;
        if (qval == '0) begin
          zero_input <= 1'b1;
          niven      <= 1'b0;
          ovalid     <= 1'b1;
        end else begin
          zero_input <= 1'b0;
          busy       <= 1'b1;
        end
      end else if (busy) begin
        // restoring remainder, one dividend bit a beat
        r     <= (r2 >= {1'b0, s}) ? SUM_BITS'(r2 - {1'b0, s}) : SUM_BITS'(r2);
        shreg <= shreg << 1;
        if (cnt == CW'(VALUE_BITS - 1)) begin
          niven  <= ((r2 >= {1'b0, s}) ? SUM_BITS'(r2 - {1'b0, s}) : SUM_BITS'(r2)) == '0;
          busy   <= 1'b0;
          ovalid <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    ovalid && zero_input |-> !niven && digit_sum == '0)
    else $error("zero input marked harshad");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst) !(busy && ovalid))
    else $error("result pending while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && !pop |=> ovalid && $stable(digit_sum) && $stable(niven))
    else $error("pending result changed");
endmodule
`default_nettype wire

// ===== rtl/harshad_number_test.sv =====
`default_nettype none
// channel | handshake      | fields
// input   | push / full    | value[VALUE_BITS-1:0]
// result  | empty / pop    | niven, digit_sum[6:0], zero_input
// A result reaches the ports once the front has converted its value to BCD one bit
// a cycle and added one digit a cycle, and the back has formed value mod digit sum
// one bit a cycle; a zero input skips the back's division.
// A two-entry queue lets the two halves overlap; the front takes no new item until
// it has pushed the last one into the queue. Reset is synchronous, no clearing pass.
// A result waiting on pop stalls the back; the front runs on until the queue is full.
module harshad_number_test import hnt_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [VALUE_BITS-1:0] value,
  output logic                       empty,
  input  wire logic                  pop,
  output logic                       niven,
  output logic [DSUM_OUT_BITS-1:0]   digit_sum,
  output logic                       zero_input
);
  localparam int NDIG     = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int SUM_BITS = $clog2(9 * NDIG + 1);

  q_stat_t                        qstat;
  logic                           qwr;
  logic                           qrd;
  logic [VALUE_BITS-1:0]          fval;
  logic [SUM_BITS-1:0]            fsum;
  logic [VALUE_BITS+SUM_BITS-1:0] qout;

  hnt_front #(.VALUE_BITS(VALUE_BITS), .NDIG(NDIG), .SUM_BITS(SUM_BITS)) u_front (
    .clk, .rst, .push, .full, .value, .qstat, .qwr, .qval(fval), .qsum(fsum)
  );

  hnt_fifo #(.W(VALUE_BITS + SUM_BITS)) u_fifo (
    .clk, .rst, .wr(qwr), .wdata({fval, fsum}), .rd(qrd), .rdata(qout), .stat(qstat)
  );

  hnt_back #(.VALUE_BITS(VALUE_BITS), .SUM_BITS(SUM_BITS)) u_back (
    .clk, .rst, .qstat,
    .qval(qout[VALUE_BITS+SUM_BITS-1:SUM_BITS]), .qsum(qout[SUM_BITS-1:0]),
    .qrd, .empty, .pop, .niven, .digit_sum, .zero_input
  );
endmodule
`default_nettype wire
